// ===== rtl/core/pdf_pkg.sv =====
// Package for the packet deframer: result kinds, queue command layout,
// buffer release record and the CRC-16 byte update.
// No dependencies.
package pdf_pkg;

   // Result kinds carried on the result channel's tuser
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_COMMAND = 2'd1,
      KIND_CRC_ERR = 2'd2
   } kind_type;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   // Command queue between parser and result sequencer
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  frame_type;
      logic [6:0]  frame_length;
      logic        bank;
   } cmd_type;

   // Payload buffer bank handed back by the sequencer
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // CRC-16, poly 0x1021, MSB first, one byte
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/packet_deframer_crc16_unit.sv =====
// Packet deframer with CRC-16 check: top level.
// Depends on pdf_pkg, pdf_front, pdf_queue, pdf_back, pdf_ram.
//
// Usage: received bytes enter on req_* one per beat. Frames are
// sync1, sync2, type, length, payload, CRC high, CRC low; the CRC-16
// (poly 0x1021, init 0, MSB first) covers the payload only. Sync bytes
// are set through csr_* (index 0 first, 1 second; reset 0xAA and 0x55).
// Results leave on rsp_*: one beat per payload byte of a good frame, one
// command beat for a zero length, one error beat on a CRC mismatch;
// rsp_tlast marks the final beat belonging to a frame.
// Throughput: one input byte per cycle and one result beat per cycle.
// The parser pushes a command into a four-deep queue; payload sits in two
// RAM banks, so the next frame's header and payload are taken while the
// previous frame drains. Input stalls only when the queue is full or the
// bank to be filled is still draining.
// The first result beat of a frame follows the CRC low byte (or the zero
// length byte) through the queue, the read stage and the output register.
// Reset returns the parser to header hunt and empties queue and output;
// there is no clearing pass. A stalled receiver holds rsp_* steady.
module packet_deframer_crc16_unit
   import pdf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic        clock,
   input  logic        reset,
   // slave side: tdata[7:0] rx_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // master side: tdata[7:0] frame_type, [15:8] payload_byte,
   // [21:16] byte_position, [28:22] frame_length, [31:29] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // tuser[1:0] kind
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              push;
   cmd_type           push_cmd;
   logic              q_full;
   logic              pop;
   logic              q_not_empty;
   cmd_type           head_cmd;
   release_type       rel;
   kind_type          kind;
   logic [7:0]        frame_type;
   logic [7:0]        payload_byte;
   logic [5:0]        byte_position;
   logic [6:0]        frame_length;

   pdf_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .buf_we     (wr_en),
      .buf_addr   (wr_addr),
      .buf_data   (wr_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (q_full),
      .rel        (rel)
   );

   pdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   pdf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pdf_back #(.IDX_W(IDX_W)) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_not_empty   (q_not_empty),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rel               (rel),
      .buf_re            (rd_en),
      .buf_addr          (rd_addr),
      .buf_rdata         (rd_data),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_kind          (kind),
      .rsp_frame_type    (frame_type),
      .rsp_payload_byte  (payload_byte),
      .rsp_byte_position (byte_position),
      .rsp_frame_length  (frame_length),
      .rsp_last          (rsp_tlast)
   );

   // Pack result fields
   assign rsp_tdata = {3'b000, frame_length, byte_position, payload_byte, frame_type};
   assign rsp_tuser = kind;

endmodule

// ===== rtl/core/pdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pdf_queue.sv =====
// Short command queue between the frame parser and the result sequencer.
// Depends on pdf_pkg.
module pdf_queue
   import pdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("command pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("command popped from an empty queue");

endmodule

// ===== rtl/core/pdf_front.sv =====
// Frame parser: hunts for the header, checks length, buffers payload into
// one of two banks, runs the CRC and pushes one command per frame that passes the length check.
// Depends on pdf_pkg.
module pdf_front
   import pdf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   parameter int IDX_W       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       rx_byte,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [7:0]       csr_wdata,
   output logic             buf_we,
   output logic [IDX_W:0]   buf_addr,
   output logic [7:0]       buf_data,
   output logic             push,
   output cmd_type          push_cmd,
   input  logic             queue_full,
   input  release_type      rel
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_TYPE  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRCHI = 3'd5,
      PH_CRCLO = 3'd6
   } phase_type;

   localparam logic CSR_FIRST_SYNC  = 1'b0;
   localparam logic CSR_SECOND_SYNC = 1'b1;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [6:0]  len_ff, len_in;
   logic [6:0]  count_ff, count_in;
   logic [7:0]  crchi_ff, crchi_in;
   logic [15:0] crc_ff, crc_in;
   logic        bank_ff, bank_in;
   logic [1:0]  busy_ff, busy_in;
   logic [7:0]  sync1_ff;
   logic [7:0]  sync2_ff;
   logic        accept;
   logic        good_push;
   logic [6:0]  count_inc;

   // Stall on a full queue, or on payload into a bank still draining
   assign req_tready = !queue_full && !(phase_ff == PH_DATA && busy_ff[bank_ff]);
   assign accept     = req_tvalid && req_tready;
   assign count_inc  = count_ff + 7'd1;

   assign buf_addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign buf_data = rx_byte;

   // Parse one byte
   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      crchi_in  = crchi_ff;
      crc_in    = crc_ff;
      bank_in   = bank_ff;
      buf_we    = 1'b0;
      push      = 1'b0;
      good_push = 1'b0;
      push_cmd  = '{kind: KIND_COMMAND, frame_type: type_ff,
                    frame_length: 7'd0, bank: bank_ff};
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (rx_byte == sync1_ff) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               phase_in = (rx_byte == sync2_ff) ? PH_TYPE : PH_HUNT1;
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (rx_byte == 8'd0) begin
                  len_in   = 7'd0;
                  push     = 1'b1;
                  phase_in = PH_HUNT1;
               end else if (rx_byte > MAX_LEN) begin
                  phase_in = PH_HUNT1;
               end else begin
                  len_in   = rx_byte[6:0];
                  count_in = 7'd0;
                  crc_in   = 16'h0000;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               buf_we   = 1'b1;
               crc_in   = crc16_update(crc_ff, rx_byte);
               count_in = count_inc;
               if (count_inc >= len_ff) begin
                  phase_in = PH_CRCHI;
               end
            end
            PH_CRCHI: begin
               crchi_in = rx_byte;
               phase_in = PH_CRCLO;
            end
            PH_CRCLO: begin
               push                  = 1'b1;
               push_cmd.frame_length = len_ff;
               if ({crchi_ff, rx_byte} == crc_ff) begin
                  push_cmd.kind = KIND_PAYLOAD;
                  good_push     = 1'b1;
                  bank_in       = !bank_ff;
               end else begin
                  push_cmd.kind = KIND_CRC_ERR;
               end
               phase_in = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   // Track banks owned by queued or draining frames
   always_comb begin
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (good_push) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         type_ff  <= 8'd0;
         len_ff   <= 7'd0;
         count_ff <= 7'd0;
         crchi_ff <= 8'd0;
         crc_ff   <= 16'h0000;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         crchi_ff <= crchi_in;
         crc_ff   <= crc_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

   // Sync byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync1_ff <= 8'hAA;
         sync2_ff <= 8'h55;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FIRST_SYNC:  sync1_ff <= csr_wdata;
            CSR_SECOND_SYNC: sync2_ff <= csr_wdata;
            default:         sync1_ff <= sync1_ff;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) buf_we |-> !busy_ff[bank_ff])
      else $error("payload written into a bank that is still draining");

   assert property (@(posedge clock) disable iff (reset) rel.valid |-> busy_ff[rel.bank])
      else $error("release of a bank that was not held");

endmodule

// ===== rtl/core/pdf_back.sv =====
// Result sequencer: pops frame commands, reads buffered payload and drives
// the result channel through a read stage and an output register.
// Depends on pdf_pkg.
module pdf_back
   import pdf_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_not_empty,
   input  cmd_type         head_cmd,
   output logic            pop,
   output release_type     rel,
   output logic            buf_re,
   output logic [IDX_W:0]  buf_addr,
   input  logic [7:0]      buf_rdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output kind_type        rsp_kind,
   output logic [7:0]      rsp_frame_type,
   output logic [7:0]      rsp_payload_byte,
   output logic [5:0]      rsp_byte_position,
   output logic [6:0]      rsp_frame_length,
   output logic            rsp_last
);

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_STREAM = 1'b1
   } state_type;

   state_type   st_ff;
   logic [6:0]  idx_ff;
   logic [7:0]  ctype_ff;
   logic [6:0]  clen_ff;
   logic        cbank_ff;

   // Read stage, aligned with RAM read data
   logic        s1_valid_ff;
   kind_type    s1_kind_ff;
   logic [7:0]  s1_type_ff;
   logic [5:0]  s1_pos_ff;
   logic [6:0]  s1_len_ff;
   logic        s1_last_ff;

   // Output register
   logic        out_valid_ff;
   kind_type    out_kind_ff;
   logic [7:0]  out_type_ff;
   logic [7:0]  out_byte_ff;
   logic [5:0]  out_pos_ff;
   logic [6:0]  out_len_ff;
   logic        out_last_ff;

   logic        out_free;
   logic        s1_free;
   logic        load_s1;
   kind_type    ld_kind;
   logic [7:0]  ld_type;
   logic [6:0]  ld_idx;
   logic [6:0]  ld_len;
   logic        ld_last;
   logic        ld_bank;

   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign load_s1  = s1_free && (st_ff == ST_STREAM || queue_not_empty);
   assign pop      = load_s1 && st_ff == ST_IDLE;

   // Choose what enters the read stage
   always_comb begin
      if (st_ff == ST_STREAM) begin
         ld_kind = KIND_PAYLOAD;
         ld_type = ctype_ff;
         ld_idx  = idx_ff;
         ld_len  = clen_ff;
         ld_bank = cbank_ff;
      end else begin
         ld_kind = head_cmd.kind;
         ld_type = head_cmd.frame_type;
         ld_idx  = 7'd0;
         ld_len  = head_cmd.frame_length;
         ld_bank = head_cmd.bank;
      end
      ld_last = (ld_kind != KIND_PAYLOAD) || (ld_idx + 7'd1 == ld_len);
   end

   assign buf_re      = load_s1 && ld_kind == KIND_PAYLOAD;
   assign buf_addr    = {ld_bank, ld_idx[IDX_W-1:0]};
   assign rel.valid   = buf_re && ld_last;
   assign rel.bank    = ld_bank;

   // Walk the payload of a good frame
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         idx_ff <= 7'd0;
      end else if (load_s1) begin
         unique case (st_ff)
            ST_IDLE: begin
               if (ld_kind == KIND_PAYLOAD && !ld_last) begin
                  st_ff  <= ST_STREAM;
                  idx_ff <= 7'd1;
               end
            end
            ST_STREAM: begin
               if (ld_last) begin
                  st_ff <= ST_IDLE;
               end
               idx_ff <= idx_ff + 7'd1;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // Capture the command being walked
   always_ff @(posedge clock) begin
      if (pop) begin
         ctype_ff <= head_cmd.frame_type;
         clen_ff  <= head_cmd.frame_length;
         cbank_ff <= head_cmd.bank;
      end
   end

   // Advance the read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= load_s1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_kind_ff <= ld_kind;
         s1_type_ff <= ld_type;
         s1_pos_ff  <= ld_idx[5:0];
         s1_len_ff  <= (ld_kind == KIND_COMMAND) ? 7'd0 : ld_len;
         s1_last_ff <= ld_last;
      end
   end

   // Output register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_kind_ff <= s1_kind_ff;
         out_type_ff <= s1_type_ff;
         out_byte_ff <= (s1_kind_ff == KIND_PAYLOAD) ? buf_rdata : 8'd0;
         out_pos_ff  <= s1_pos_ff;
         out_len_ff  <= s1_len_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_frame_type    = out_type_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_frame_length  = out_len_ff;
   assign rsp_last          = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && out_kind_ff != KIND_PAYLOAD)
                    |-> (out_byte_ff == 8'd0 && out_pos_ff == 6'd0 && out_last_ff))
      else $error("command or error result with payload fields set");

endmodule
